// ===== design/hsvf_pkg.sv =====
// Shared widths, configuration register indexes and divider word type for the HSV window filter.
`default_nettype none

package hsvf_pkg;

  localparam int ChanW    = 8;  // colour channel, saturation and margin width
  localparam int HueW     = 9;  // hue in whole degrees
  localparam int QuotW    = 9;  // quotient bits produced by each divider
  localparam int DivSteps = 3;  // restoring steps done in one divider stage
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 9;  // widest register is target_hue

  localparam logic [HueW-1:0] HueFold = 9'd180;
  localparam logic [HueW-1:0] HueFull = 9'd360;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgTargetHue = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTargetSat = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgTargetVal = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgHueMargin = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSatMargin = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgValMargin = 3'd5;

  // partial remainder, dividend bits still to consume (quotient shifts in at
  // the bottom) and the divisor
  typedef struct packed {
    logic [ChanW-1:0] rem;
    logic [QuotW-1:0] dq;
    logic [ChanW-1:0] dvsr;
  } div_t;

endpackage

`default_nettype wire

// ===== design/hsvf_div_stage.sv =====
// Three restoring-division steps of a pipelined 17-by-8 bit divider.
`default_nettype none

module hsvf_div_stage (
  input  wire hsvf_pkg::div_t din,
  output hsvf_pkg::div_t      dout
);

  import hsvf_pkg::*;

  always_comb begin : div_steps
    logic [ChanW:0] x;
    div_t           w;
    w = din;
    x = '0;
    for (int i = 0; i < DivSteps; i++) begin
      // bring down the next dividend bit, subtract where it fits
      x = {w.rem, w.dq[QuotW-1]};
      if (x >= {1'b0, w.dvsr}) begin
        w.rem = ChanW'(x - {1'b0, w.dvsr});
        w.dq  = {w.dq[QuotW-2:0], 1'b1};
      end else begin
        w.rem = x[ChanW-1:0];
        w.dq  = {w.dq[QuotW-2:0], 1'b0};
      end
    end
    dout = w;
  end

endmodule

`default_nettype wire

// ===== design/hsv_color_window_filter_unit.sv =====
// Top level of the RGB to HSV converter with configurable HSV acceptance window.
`default_nettype none

// Path: a word taken at a rising edge (start high, busy low) passes through
//   registers s1 to s5 to the result ports, where it is held for one cycle
//   with result_valid high.
// Throughput: one word per cycle; busy never rises, since every stage moves on
//   each cycle and both dividers are three-stage pipelines of three bits each.
// Reset: clears every pipeline valid bit (words in flight are dropped) and
//   loads the configuration defaults: targets 0, hue margin 180, others 255.

module hsv_color_window_filter_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [hsvf_pkg::ChanW-1:0]    red,
  input  wire logic [hsvf_pkg::ChanW-1:0]    green,
  input  wire logic [hsvf_pkg::ChanW-1:0]    blue,
  input  wire logic                          cfg_write,
  input  wire logic [hsvf_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [hsvf_pkg::CfgDataW-1:0] cfg_data,
  output logic                               result_valid,
  output logic                               accept,
  output logic [hsvf_pkg::HueW-1:0]          hue_deg,
  output logic [hsvf_pkg::ChanW-1:0]         sat_level,
  output logic [hsvf_pkg::ChanW-1:0]         val_level
);

  import hsvf_pkg::*;

  localparam int TW = 18;  // signed hue numerator, up to 360 * 255

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } sel_t;

  // after channel sort: largest channel, chroma and the sector difference
  typedef struct packed {
    logic             valid;
    sel_t             sel;
    logic [ChanW-1:0] v;
    logic [ChanW-1:0] d;
    logic [ChanW:0]   n;  // two's complement difference of the other channels
  } sort_t;

  // divider pipeline word
  typedef struct packed {
    logic             valid;
    logic [ChanW-1:0] v;
    logic             hue_en;
    div_t             hdiv;
    div_t             sdiv;
  } pipe_t;

  // configuration registers
  logic [HueW-1:0]  target_hue;
  logic [ChanW-1:0] target_sat;
  logic [ChanW-1:0] target_val;
  logic [ChanW-1:0] hue_margin;
  logic [ChanW-1:0] sat_margin;
  logic [ChanW-1:0] val_margin;

  sort_t s1;
  sort_t s1_next;
  pipe_t s2;
  pipe_t s2_next;
  pipe_t s3;
  pipe_t s3_next;
  pipe_t s4;
  pipe_t s4_next;
  pipe_t s5;
  pipe_t s5_next;

  logic             accept_next;
  logic [HueW-1:0]  hue_next;
  logic [ChanW-1:0] sat_next;

  // The pipeline never stalls, so a new word is taken every cycle.
  assign busy = 1'b0;

  // Configuration writes; an index past the last register is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_hue <= '0;
      target_sat <= '0;
      target_val <= '0;
      hue_margin <= ChanW'(HueFold);
      sat_margin <= '1;
      val_margin <= '1;
    end else if (cfg_write) begin
      case (cfg_index)
        CfgTargetHue: target_hue <= cfg_data[HueW-1:0];
        CfgTargetSat: target_sat <= cfg_data[ChanW-1:0];
        CfgTargetVal: target_val <= cfg_data[ChanW-1:0];
        CfgHueMargin: hue_margin <= cfg_data[ChanW-1:0];
        CfgSatMargin: sat_margin <= cfg_data[ChanW-1:0];
        CfgValMargin: val_margin <= cfg_data[ChanW-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: find the largest channel (red, then green, then blue win ties),
  // the smallest, the chroma and the difference that sets the hue offset.
  always_comb begin : sort_logic
    logic [ChanW-1:0] mx;
    logic [ChanW-1:0] mn;
    sel_t             sel;
    mx  = red;
    sel = SEL_RED;
    if (green > mx) begin
      mx  = green;
      sel = SEL_GREEN;
    end
    if (blue > mx) begin
      mx  = blue;
      sel = SEL_BLUE;
    end
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn)  mn = blue;

    s1_next.valid = start && !busy;
    s1_next.sel   = sel;
    s1_next.v     = mx;
    s1_next.d     = mx - mn;
    case (sel)
      SEL_GREEN: s1_next.n = {1'b0, blue} - {1'b0, red};
      SEL_BLUE:  s1_next.n = {1'b0, red} - {1'b0, green};
      default:   s1_next.n = {1'b0, green} - {1'b0, blue};
    endcase
  end

  // Stage 2: build the hue numerator 60*n plus the sector base, wrapped
  // into the positive range, the saturation numerator 255*d and the hue enable 100*d > v.
  always_comb begin : numer_logic
    logic [TW-1:0]      d_x;
    logic [TW-1:0]      n_x;
    logic [TW-1:0]      base;
    logic [TW-1:0]      t;
    logic [TW-1:0]      full;
    logic [2*ChanW:0]   snum;
    logic [2*ChanW-2:0] d100;
    d_x  = {{(TW-ChanW){1'b0}}, s1.d};
    n_x  = {{(TW-ChanW-1){s1.n[ChanW]}}, s1.n};
    full = (d_x << 8) + (d_x << 6) + (d_x << 5) + (d_x << 3);
    case (s1.sel)
      SEL_GREEN: base = (d_x << 7) - (d_x << 3);
      SEL_BLUE:  base = (d_x << 8) - (d_x << 4);
      default:   base = '0;
    endcase
    t = base + (n_x << 6) - (n_x << 2);
    if (t[TW-1]) t = t + full;

    snum = {1'b0, s1.d, {ChanW{1'b0}}} - {{(ChanW+1){1'b0}}, s1.d};
    d100 = {{(ChanW-1){1'b0}}, s1.d};
    d100 = (d100 << 6) + (d100 << 5) + (d100 << 2);

    s2_next.valid       = s1.valid;
    s2_next.v           = s1.v;
    s2_next.hue_en      = d100 > {{(ChanW-1){1'b0}}, s1.v};
    s2_next.hdiv.rem    = t[TW-2:QuotW];
    s2_next.hdiv.dq     = t[QuotW-1:0];
    s2_next.hdiv.dvsr   = s1.d;
    s2_next.sdiv.rem    = snum[2*ChanW:QuotW];
    s2_next.sdiv.dq     = snum[QuotW-1:0];
    s2_next.sdiv.dvsr   = s1.v;
  end

  // Stages 3 to 5: three quotient bits of each divider per stage.
  assign s3_next.valid  = s2.valid;
  assign s3_next.v      = s2.v;
  assign s3_next.hue_en = s2.hue_en;
  assign s4_next.valid  = s3.valid;
  assign s4_next.v      = s3.v;
  assign s4_next.hue_en = s3.hue_en;
  assign s5_next.valid  = s4.valid;
  assign s5_next.v      = s4.v;
  assign s5_next.hue_en = s4.hue_en;

  hsvf_div_stage u_hdiv_a (.din(s2.hdiv), .dout(s3_next.hdiv));
  hsvf_div_stage u_sdiv_a (.din(s2.sdiv), .dout(s3_next.sdiv));
  hsvf_div_stage u_hdiv_b (.din(s3.hdiv), .dout(s4_next.hdiv));
  hsvf_div_stage u_sdiv_b (.din(s3.sdiv), .dout(s4_next.sdiv));
  hsvf_div_stage u_hdiv_c (.din(s4.hdiv), .dout(s5_next.hdiv));
  hsvf_div_stage u_sdiv_c (.din(s4.sdiv), .dout(s5_next.sdiv));

  // Output stage: mask the quotients for black and weak chroma, then test
  // the three distances against their margins.
  always_comb begin : window_logic
    logic [HueW-1:0]  hd;
    logic [ChanW-1:0] sd;
    logic [ChanW-1:0] vd;
    hue_next = s5.hue_en ? s5.hdiv.dq : '0;
    sat_next = (s5.v != '0) ? s5.sdiv.dq[ChanW-1:0] : '0;

    hd = (hue_next >= target_hue) ? hue_next - target_hue : target_hue - hue_next;
    // fold the circular distance; a target above 359 can push it to 360+
    if (hd > HueFold) begin
      hd = (hd >= HueFull) ? '0 : HueFull - hd;
    end
    sd = (sat_next >= target_sat) ? sat_next - target_sat : target_sat - sat_next;
    vd = (s5.v >= target_val) ? s5.v - target_val : target_val - s5.v;

    accept_next = (hd <= {1'b0, hue_margin}) && (sd <= sat_margin) && (vd <= val_margin);
  end

  // Advance the pipeline; only the valid bits are reset, payload needs none.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid     <= 1'b0;
      s2.valid     <= 1'b0;
      s3.valid     <= 1'b0;
      s4.valid     <= 1'b0;
      s5.valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1.valid     <= s1_next.valid;
      s2.valid     <= s2_next.valid;
      s3.valid     <= s3_next.valid;
      s4.valid     <= s4_next.valid;
      s5.valid     <= s5_next.valid;
      result_valid <= s5.valid;
    end
    s1.sel    <= s1_next.sel;
    s1.v      <= s1_next.v;
    s1.d      <= s1_next.d;
    s1.n      <= s1_next.n;
    s2.v      <= s2_next.v;
    s2.hue_en <= s2_next.hue_en;
    s2.hdiv   <= s2_next.hdiv;
    s2.sdiv   <= s2_next.sdiv;
    s3.v      <= s3_next.v;
    s3.hue_en <= s3_next.hue_en;
    s3.hdiv   <= s3_next.hdiv;
    s3.sdiv   <= s3_next.sdiv;
    s4.v      <= s4_next.v;
    s4.hue_en <= s4_next.hue_en;
    s4.hdiv   <= s4_next.hdiv;
    s4.sdiv   <= s4_next.sdiv;
    s5.v      <= s5_next.v;
    s5.hue_en <= s5_next.hue_en;
    s5.hdiv   <= s5_next.hdiv;
    s5.sdiv   <= s5_next.sdiv;
    accept    <= accept_next;
    hue_deg   <= hue_next;
    sat_level <= sat_next;
    val_level <= s5.v;
  end

  // every accepted word comes out with result_valid high
  a_word_out: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##6 result_valid)
    else $error("accepted word did not appear after six cycles");

  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy, 6))
    else $error("result without a matching accepted word");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (hue_deg < HueFull))
    else $error("hue quotient out of range");

  a_black: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (val_level == '0)) |-> ((sat_level == '0) && (hue_deg == '0)))
    else $error("black input gave non-zero hue or saturation");

endmodule

`default_nettype wire
